// ===== design/rdt_pkg.sv =====
// Shared types and defaults for the request deadline table.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package rdt_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int ID_WIDTH_DEF   = 16;
   localparam int TIME_WIDTH_DEF = 32;

   localparam int TYPE_WIDTH   = 2;
   localparam int STATUS_WIDTH = 3;

   typedef enum logic [TYPE_WIDTH-1:0] {
      OP_SET    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_TICK   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STAT_INSERTED  = 3'd0,
      STAT_UPDATED   = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_REMOVED   = 3'd3,
      STAT_NOT_FOUND = 3'd4,
      STAT_EXPIRED   = 3'd5,
      STAT_NONE      = 3'd6
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic ready;     // input channel may take a beat
      logic start;     // beat taken: latch item, restart scan
      logic scan;      // a slot is under inspection this cycle
      logic advance;   // step to the next slot
      logic act;       // apply the hit action at the current slot
      logic finish;    // emit the closing result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type kind;
      logic   req_valid;
      logic   hit;
      logic   at_end;
      logic   out_busy;
      logic   pend_valid;
   } stat_type;

endpackage

`default_nettype wire

// ===== design/rdt_req_if.sv =====
// Input channel of the request deadline table: valid/ready plus item fields.
// Depends on rdt_pkg for default widths.
`default_nettype none

interface rdt_req_if #(
   parameter int ID_WIDTH   = rdt_pkg::ID_WIDTH_DEF,
   parameter int TIME_WIDTH = rdt_pkg::TIME_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic [rdt_pkg::TYPE_WIDTH-1:0] req_type;
   logic [ID_WIDTH-1:0]            request_id;
   logic [TIME_WIDTH-1:0]          deadline;
   logic [TIME_WIDTH-1:0]          now_time;

   modport source (output valid, req_type, request_id, deadline, now_time, input ready);
   modport sink   (input valid, req_type, request_id, deadline, now_time, output ready);
endinterface

`default_nettype wire

// ===== design/rdt_rsp_if.sv =====
// Result channel of the request deadline table: valid/ready plus result fields.
// Depends on rdt_pkg for default widths.
`default_nettype none

interface rdt_rsp_if #(
   parameter int ID_WIDTH = rdt_pkg::ID_WIDTH_DEF
);
   logic                             valid;
   logic                             ready;
   logic [rdt_pkg::STATUS_WIDTH-1:0] status;
   logic [ID_WIDTH-1:0]              result_id;
   logic                             last;

   modport source (output valid, status, result_id, last, input ready);
   modport sink   (input valid, status, result_id, last, output ready);
endinterface

`default_nettype wire

// ===== design/rdt_ctrl.sv =====
// Sequencer for the deadline table: walks the slot scan, decides stalls.
// Depends on rdt_pkg (cmd_type, stat_type, op_type).
`default_nettype none

module rdt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rdt_pkg::stat_type status,
   output rdt_pkg::cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (status.req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.kind == rdt_pkg::OP_NONE) begin
               state_in = S_IDLE;
            end else if (status.hit && status.kind == rdt_pkg::OP_TICK) begin
               // the held expiry goes out before the new one replaces it
               if (!(status.pend_valid && status.out_busy)) begin
                  cmd.act = 1'b1;
                  if (status.at_end) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.advance = 1'b1;
                  end
               end
            end else if (status.hit) begin
               if (!status.out_busy) begin
                  cmd.act  = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (status.at_end) begin
               state_in = S_DONE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_DONE: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/rdt_dp.sv =====
// Datapath of the deadline table: slot memories, valid bits, scan index,
// held expiry and the result register. Depends on rdt_pkg and both channel interfaces.
`default_nettype none

module rdt_dp #(
   parameter int CAPACITY   = rdt_pkg::CAPACITY_DEF,
   parameter int ID_WIDTH   = rdt_pkg::ID_WIDTH_DEF,
   parameter int TIME_WIDTH = rdt_pkg::TIME_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   rdt_req_if.sink               req_bus,
   rdt_rsp_if.source             rsp_bus,
   input  wire rdt_pkg::cmd_type cmd,
   output rdt_pkg::stat_type     status
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   logic [ID_WIDTH-1:0]   id_mem [CAPACITY];
   logic [TIME_WIDTH-1:0] dl_mem [CAPACITY];

   rdt_pkg::op_type       kind_ff;
   logic [ID_WIDTH-1:0]   id_ff;
   logic [TIME_WIDTH-1:0] dl_ff;
   logic [TIME_WIDTH-1:0] now_ff;

   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CAPACITY-1:0]   valid_ff;
   logic [ID_WIDTH-1:0]   rd_id_ff;
   logic [TIME_WIDTH-1:0] rd_dl_ff;

   logic                  free_found_ff;
   logic [IDX_W-1:0]      free_slot_ff;
   logic                  pend_valid_ff;
   logic [ID_WIDTH-1:0]   pend_id_ff;

   logic                  out_valid_ff;
   rdt_pkg::status_type   out_status_ff;
   logic [ID_WIDTH-1:0]   out_id_ff;
   logic                  out_last_ff;

   logic                  cur_valid, id_match, expire, hit;
   logic                  push, push_last;
   rdt_pkg::status_type   push_status;
   logic [ID_WIDTH-1:0]   push_id;
   logic                  mem_we, mem_we_id;
   logic [IDX_W-1:0]      wr_addr;
   logic                  set_valid, clr_valid;
   logic [IDX_W-1:0]      vbit_addr;

   // read data always reflects the slot at idx_ff, also across stalls
   assign idx_in = cmd.start ? '0 : (cmd.advance ? idx_ff + 1'b1 : idx_ff);

   assign cur_valid = valid_ff[idx_ff];
   assign id_match  = cur_valid && (rd_id_ff == id_ff);
   assign expire    = cur_valid && (rd_dl_ff <= now_ff);

   always_comb begin
      case (kind_ff)
         rdt_pkg::OP_SET, rdt_pkg::OP_REMOVE: hit = id_match;
         rdt_pkg::OP_TICK:                    hit = expire;
         default:                             hit = 1'b0;
      endcase
   end

   always_comb begin
      push        = 1'b0;
      push_status = rdt_pkg::STAT_NONE;
      push_id     = id_ff;
      push_last   = 1'b1;
      mem_we      = 1'b0;
      mem_we_id   = 1'b0;
      wr_addr     = idx_ff;
      set_valid   = 1'b0;
      clr_valid   = 1'b0;
      vbit_addr   = idx_ff;
      if (cmd.act) begin
         case (kind_ff)
            rdt_pkg::OP_SET: begin
               push        = 1'b1;
               push_status = rdt_pkg::STAT_UPDATED;
               mem_we      = 1'b1;
            end
            rdt_pkg::OP_REMOVE: begin
               push        = 1'b1;
               push_status = rdt_pkg::STAT_REMOVED;
               clr_valid   = 1'b1;
            end
            rdt_pkg::OP_TICK: begin
               clr_valid   = 1'b1;
               push        = pend_valid_ff;
               push_status = rdt_pkg::STAT_EXPIRED;
               push_id     = pend_id_ff;
               push_last   = 1'b0;
            end
            default: ;
         endcase
      end else if (cmd.finish) begin
         push = 1'b1;
         case (kind_ff)
            rdt_pkg::OP_SET: begin
               if (free_found_ff) begin
                  push_status = rdt_pkg::STAT_INSERTED;
                  mem_we      = 1'b1;
                  mem_we_id   = 1'b1;
                  wr_addr     = free_slot_ff;
                  set_valid   = 1'b1;
                  vbit_addr   = free_slot_ff;
               end else begin
                  push_status = rdt_pkg::STAT_FULL;
               end
            end
            rdt_pkg::OP_REMOVE: push_status = rdt_pkg::STAT_NOT_FOUND;
            rdt_pkg::OP_TICK: begin
               if (pend_valid_ff) begin
                  push_status = rdt_pkg::STAT_EXPIRED;
                  push_id     = pend_id_ff;
               end else begin
                  push_status = rdt_pkg::STAT_NONE;
                  push_id     = '0;
               end
            end
            default: push = 1'b0;
         endcase
      end
   end

   // slot memories
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dl_mem[wr_addr] <= dl_ff;
         if (mem_we_id) begin
            id_mem[wr_addr] <= id_ff;
         end
      end
      rd_id_ff <= id_mem[idx_in];
      rd_dl_ff <= dl_mem[idx_in];
   end

   // item fields, held for the whole scan; also the free slot, held expiry id and result
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kind_ff <= rdt_pkg::op_type'(req_bus.req_type);
         id_ff   <= req_bus.request_id;
         dl_ff   <= req_bus.deadline;
         now_ff  <= req_bus.now_time;
      end
      if (cmd.scan && !cur_valid && !free_found_ff) begin
         free_slot_ff <= idx_ff;
      end
      if (cmd.act && kind_ff == rdt_pkg::OP_TICK) begin
         pend_id_ff <= rd_id_ff;
      end
      if (push && (!out_valid_ff || rsp_bus.ready)) begin
         out_status_ff <= push_status;
         out_id_ff     <= push_id;
         out_last_ff   <= push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         valid_ff      <= '0;
         free_found_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (set_valid) begin
            valid_ff[vbit_addr] <= 1'b1;
         end else if (clr_valid) begin
            valid_ff[vbit_addr] <= 1'b0;
         end
         if (cmd.start) begin
            free_found_ff <= 1'b0;
         end else if (cmd.scan && !cur_valid) begin
            free_found_ff <= 1'b1;
         end
         if (cmd.start || cmd.finish) begin
            pend_valid_ff <= 1'b0;
         end else if (cmd.act && kind_ff == rdt_pkg::OP_TICK) begin
            pend_valid_ff <= 1'b1;
         end
         if (push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign req_bus.ready     = cmd.ready;
   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.status    = out_status_ff;
   assign rsp_bus.result_id = out_id_ff;
   assign rsp_bus.last      = out_last_ff;

   assign status.kind       = kind_ff;
   assign status.req_valid  = req_bus.valid;
   assign status.hit        = hit;
   assign status.at_end     = (idx_ff == LAST_IDX);
   assign status.out_busy   = out_valid_ff && !rsp_bus.ready;
   assign status.pend_valid = pend_valid_ff;

endmodule

`default_nettype wire

// ===== design/request_deadline_table.sv =====
// Top level of the request deadline table: controller plus datapath.
// Depends on rdt_pkg, rdt_req_if, rdt_rsp_if, rdt_ctrl and rdt_dp.
//
//   channel   dir  beat fields
//   req_bus   in   req_type, request_id, deadline, now_time
//   rsp_bus   out  status, result_id, last
//
// One item at a time. A set or remove scans slot by slot, one slot per cycle from
// the slot memory read port, and stops at the matching slot. A tick always scans
// all CAPACITY slots. Reset clears the valid flops at once; no clearing pass. A busy
// result register can hold the scan at a hit slot until the beat is taken.
`default_nettype none

module request_deadline_table #(
   parameter int CAPACITY   = rdt_pkg::CAPACITY_DEF,
   parameter int ID_WIDTH   = rdt_pkg::ID_WIDTH_DEF,
   parameter int TIME_WIDTH = rdt_pkg::TIME_WIDTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   rdt_req_if.sink   req_bus,
   rdt_rsp_if.source rsp_bus
);

   rdt_pkg::cmd_type  cmd;
   rdt_pkg::stat_type status;

   rdt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   rdt_dp #(
      .CAPACITY   (CAPACITY),
      .ID_WIDTH   (ID_WIDTH),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cmd     (cmd),
      .status  (status)
   );

endmodule

`default_nettype wire

// ===== sim/tb_request_deadline_table.sv =====
// Self-checking testbench for request_deadline_table: directed rows, then random beats.
// A shadow deadline table predicts every result. Needs rdt_pkg, rdt_req_if, rdt_rsp_if
// and the design.

module tb_request_deadline_table;

   localparam int SLOTS  = rdt_pkg::CAPACITY_DEF;
   localparam int ID_W   = rdt_pkg::ID_WIDTH_DEF;
   localparam int TIME_W = rdt_pkg::TIME_WIDTH_DEF;
   localparam int POOL   = 40;

   typedef logic [ID_W-1:0]   id_type;
   typedef logic [TIME_W-1:0] stamp_type;

   typedef struct packed {
      rdt_pkg::status_type status;
      id_type              id;
      logic                last;
   } rsp_beat_type;

   typedef struct packed {
      rdt_pkg::op_type     op;
      id_type              id;
      stamp_type           dl;
      stamp_type           now;
      logic                known;   // result written into the row
      rdt_pkg::status_type st;
      id_type              rid;
   } dir_row_type;

   localparam int N_ROWS = 19;
   localparam dir_row_type DIRECTED_ROWS [N_ROWS] = '{
      '{rdt_pkg::OP_REMOVE, 16'h0000, 32'h0000_0000, 32'h0000_0000,
        1'b1, rdt_pkg::STAT_NOT_FOUND, 16'h0000},
      '{rdt_pkg::OP_TICK,   16'h0000, 32'h0000_0000, 32'h0000_0000,
        1'b1, rdt_pkg::STAT_NONE,      16'h0000},
      '{rdt_pkg::OP_SET,    16'h0000, 32'h0000_0000, 32'h0000_0000,
        1'b1, rdt_pkg::STAT_INSERTED,  16'h0000},
      '{rdt_pkg::OP_SET,    16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        1'b1, rdt_pkg::STAT_INSERTED,  16'hFFFF},
      '{rdt_pkg::OP_SET,    16'h0000, 32'h0000_000A, 32'h0000_0000,
        1'b1, rdt_pkg::STAT_UPDATED,   16'h0000},
      '{rdt_pkg::OP_TICK,   16'h0000, 32'h0000_0000, 32'h0000_0009,
        1'b1, rdt_pkg::STAT_NONE,      16'h0000},
      // deadline equal to now expires
      '{rdt_pkg::OP_TICK,   16'h0000, 32'h0000_0000, 32'h0000_000A,
        1'b1, rdt_pkg::STAT_EXPIRED,   16'h0000},
      // unknown type: no result, no state change
      '{rdt_pkg::OP_NONE,   16'h1234, 32'h0000_0000, 32'h0000_0000,
        1'b0, rdt_pkg::STAT_NONE,      16'h0000},
      '{rdt_pkg::OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000,
        1'b1, rdt_pkg::STAT_REMOVED,   16'hFFFF},
      '{rdt_pkg::OP_REMOVE, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        1'b1, rdt_pkg::STAT_NOT_FOUND, 16'hFFFF},
      '{rdt_pkg::OP_SET,    16'h0005, 32'hFFFF_FFFF, 32'h0000_0000,
        1'b1, rdt_pkg::STAT_INSERTED,  16'h0005},
      '{rdt_pkg::OP_SET,    16'h0006, 32'h0000_0000, 32'h0000_0000,
        1'b1, rdt_pkg::STAT_INSERTED,  16'h0006},
      '{rdt_pkg::OP_SET,    16'h0007, 32'h0000_0064, 32'h0000_0000,
        1'b1, rdt_pkg::STAT_INSERTED,  16'h0007},
      '{rdt_pkg::OP_SET,    16'hA5A5, 32'h8000_0000, 32'h0000_0000,
        1'b1, rdt_pkg::STAT_INSERTED,  16'hA5A5},
      '{rdt_pkg::OP_REMOVE, 16'h0006, 32'h0000_0000, 32'h0000_0000,
        1'b1, rdt_pkg::STAT_REMOVED,   16'h0006},
      // refills the lowest free slot
      '{rdt_pkg::OP_SET,    16'h0006, 32'h0000_0000, 32'h0000_0000,
        1'b1, rdt_pkg::STAT_INSERTED,  16'h0006},
      '{rdt_pkg::OP_TICK,   16'h0000, 32'h0000_0000, 32'h7FFF_FFFF,
        1'b0, rdt_pkg::STAT_NONE,      16'h0000},
      '{rdt_pkg::OP_TICK,   16'h0000, 32'h0000_0000, 32'hFFFF_FFFF,
        1'b0, rdt_pkg::STAT_NONE,      16'h0000},
      '{rdt_pkg::OP_TICK,   16'h0000, 32'h0000_0000, 32'hFFFF_FFFF,
        1'b1, rdt_pkg::STAT_NONE,      16'h0000}
   };

   logic clock;
   logic reset;

   rdt_req_if req_bus ();
   rdt_rsp_if rsp_bus ();

   request_deadline_table u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // shadow copy of the table
   bit        shadow_valid    [SLOTS];
   id_type    shadow_id       [SLOTS];
   stamp_type shadow_deadline [SLOTS];

   rsp_beat_type step_rsp[$];      // results of the latest accepted beat
   rsp_beat_type pending_rsp[$];   // results still owed by the design

   id_type    id_pool [POOL];
   stamp_type sim_now;
   bit        quiet_tail;
   int        error_count;
   int        items_sent;
   int        ignored_sent;
   int        results_seen;
   int        status_seen [8];

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #15_000_000;
      $display("request_deadline_table test failed");
      $finish;
   end

   function automatic rsp_beat_type beat_of(rdt_pkg::status_type s, id_type id, logic last);
      rsp_beat_type b;
      b.status = s;
      b.id     = id;
      b.last   = last;
      return b;
   endfunction

   function automatic int find_slot(id_type id);
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i] && shadow_id[i] == id) return i;
      return -1;
   endfunction

   task automatic apply_deadline_op(rdt_pkg::op_type op, id_type id, stamp_type dl,
                                    stamp_type now);
      int  hit;
      bit  placed;
      step_rsp.delete();
      hit    = find_slot(id);
      placed = 1'b0;
      case (op)
         rdt_pkg::OP_SET: begin
            if (hit >= 0) begin
               shadow_deadline[hit] = dl;
               step_rsp.push_back(beat_of(rdt_pkg::STAT_UPDATED, id, 1'b1));
            end else begin
               for (int i = 0; i < SLOTS && !placed; i++) begin
                  if (!shadow_valid[i]) begin
                     shadow_valid[i]    = 1'b1;
                     shadow_id[i]       = id;
                     shadow_deadline[i] = dl;
                     placed             = 1'b1;
                  end
               end
               if (placed)
                  step_rsp.push_back(beat_of(rdt_pkg::STAT_INSERTED, id, 1'b1));
               else
                  step_rsp.push_back(beat_of(rdt_pkg::STAT_FULL, id, 1'b1));
            end
         end
         rdt_pkg::OP_REMOVE: begin
            if (hit >= 0) begin
               shadow_valid[hit] = 1'b0;
               step_rsp.push_back(beat_of(rdt_pkg::STAT_REMOVED, id, 1'b1));
            end else begin
               step_rsp.push_back(beat_of(rdt_pkg::STAT_NOT_FOUND, id, 1'b1));
            end
         end
         rdt_pkg::OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (shadow_valid[i] && shadow_deadline[i] <= now) begin
                  shadow_valid[i] = 1'b0;
                  step_rsp.push_back(beat_of(rdt_pkg::STAT_EXPIRED, shadow_id[i], 1'b0));
               end
            end
            if (step_rsp.size() == 0)
               step_rsp.push_back(beat_of(rdt_pkg::STAT_NONE, '0, 1'b1));
            else
               step_rsp[step_rsp.size()-1].last = 1'b1;
         end
         default: ;
      endcase
   endtask

   // holds valid across back-to-back beats; idle_gap and wait_drained lower it
   task automatic send_beat(rdt_pkg::op_type op, id_type id, stamp_type dl, stamp_type now);
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= op;
      req_bus.request_id <= id;
      req_bus.deadline   <= dl;
      req_bus.now_time   <= now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      apply_deadline_op(op, id, dl, now);
      if (op == rdt_pkg::OP_NONE) ignored_sent++;
      else items_sent++;
   endtask

   task automatic queue_step();
      foreach (step_rsp[i]) pending_rsp.push_back(step_rsp[i]);
   endtask

   task automatic idle_gap();
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic random_item();
      int              pick;
      int              r;
      rdt_pkg::op_type op;
      id_type          id;
      stamp_type       dl;
      stamp_type       now;
      pick = $urandom_range(0, 99);
      id   = ($urandom_range(0, 6) == 0) ? id_type'($urandom)
                                         : id_pool[$urandom_range(0, POOL-1)];
      dl   = ($urandom_range(0, 9) == 0) ? stamp_type'($urandom)
                                         : stamp_type'(sim_now + $urandom_range(0, 50));
      now  = stamp_type'($urandom);
      if (pick < 45)      op = rdt_pkg::OP_SET;
      else if (pick < 70) op = rdt_pkg::OP_REMOVE;
      else if (pick < 92) op = rdt_pkg::OP_TICK;
      else                op = rdt_pkg::OP_NONE;
      if (op == rdt_pkg::OP_TICK) begin
         r = $urandom_range(0, 9);
         if (r != 0) begin
            if (r > 1) sim_now = sim_now + $urandom_range(1, 15);
            now = sim_now;
         end
      end
      idle_gap();
      send_beat(op, id, dl, now);
      queue_step();
   endtask

   // result side: ready in random bursts, steady in the tail
   initial begin
      int run;
      bit hold;
      run  = 0;
      hold = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (quiet_tail) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            if (run == 0) begin
               hold = ($urandom_range(0, 2) == 0);
               run  = hold ? $urandom_range(1, 12) : $urandom_range(1, 30);
            end
            rsp_bus.ready <= !hold;
            run--;
         end
      end
   end

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         status_seen[rsp_bus.status]++;
         if (pending_rsp.size() == 0) begin
            error_count++;
            if (error_count <= 50)
               $display("%0t: unexpected result beat status %0d id %h last %0d",
                        $time, rsp_bus.status, rsp_bus.result_id, rsp_bus.last);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.status !== want.status || rsp_bus.result_id !== want.id ||
                rsp_bus.last !== want.last) begin
               error_count++;
               if (error_count <= 50)
                  $display("%0t: mismatch expected status %0d id %h last %0d, got %0d %h %0d",
                           $time, want.status, want.id, want.last,
                           rsp_bus.status, rsp_bus.result_id, rsp_bus.last);
            end
         end
      end
   end

   initial begin
      dir_row_type row;
      id_type      fill_base;
      int          extra;
      quiet_tail   = 1'b0;
      error_count  = 0;
      items_sent   = 0;
      ignored_sent = 0;
      results_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      foreach (id_pool[i]) id_pool[i] = id_type'($urandom);
      sim_now = stamp_type'($urandom);

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= rdt_pkg::OP_SET;
      req_bus.request_id <= '0;
      req_bus.deadline   <= '0;
      req_bus.now_time   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < N_ROWS; r++) begin
         row = DIRECTED_ROWS[r];
         idle_gap();
         send_beat(row.op, row.id, row.dl, row.now);
         if (row.known) pending_rsp.push_back(beat_of(row.st, row.rid, 1'b1));
         else queue_step();
      end

      while (items_sent < N_ROWS + 90) random_item();

      // hold off until every owed result has come back
      wait_drained();

      // fill the table, run into full, then churn while full
      fill_base = id_type'($urandom);
      extra     = 0;
      for (int k = 0; k < 2 * SLOTS && extra < 4; k++) begin
         idle_gap();
         send_beat(rdt_pkg::OP_SET, id_type'(fill_base + k),
                   stamp_type'(sim_now + $urandom_range(0, 60)), stamp_type'($urandom));
         queue_step();
         if (step_rsp[0].status == rdt_pkg::STAT_FULL) extra++;
      end
      idle_gap();
      send_beat(rdt_pkg::OP_REMOVE, shadow_id[SLOTS/2], stamp_type'($urandom),
                stamp_type'($urandom));
      queue_step();
      idle_gap();
      send_beat(rdt_pkg::OP_SET, id_type'(fill_base + 16'h8000), sim_now,
                stamp_type'($urandom));
      queue_step();
      idle_gap();
      send_beat(rdt_pkg::OP_SET, shadow_id[0], stamp_type'(sim_now + 5),
                stamp_type'($urandom));
      queue_step();
      idle_gap();
      send_beat(rdt_pkg::OP_TICK, '0, '0, stamp_type'(sim_now + 30));
      queue_step();
      idle_gap();
      send_beat(rdt_pkg::OP_TICK, '0, '0, '1);
      queue_step();
      wait_drained();

      quiet_tail = 1'b1;
      extra = items_sent;
      while (items_sent < extra + 90) random_item();
      req_bus.valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SLOTS + 16) @(posedge clock);

      $display("covered %0d requests and %0d ignored beats, %0d result beats checked",
               items_sent, ignored_sent, results_seen);
      $display("  %0d expired, %0d full refusals, %0d updates, %0d misses on remove",
               status_seen[rdt_pkg::STAT_EXPIRED], status_seen[rdt_pkg::STAT_FULL],
               status_seen[rdt_pkg::STAT_UPDATED], status_seen[rdt_pkg::STAT_NOT_FOUND]);
      if (error_count == 0)
         $display("request_deadline_table test passed");
      else
         $display("request_deadline_table test failed");
      $finish;
   end

endmodule
